>>> rtl/core/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg: shared definitions for the positional circular list
// Request function codes, internal operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package pcl_pkg;

   // Fixed widths of the request and response fields.
   localparam int FUNC_W  = 4;
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int FIDX_W  = 6;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 4'd0;
   localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_ADD_AT    = 4'd2;
   localparam logic [FUNC_W-1:0] FN_REM_FRONT = 4'd3;
   localparam logic [FUNC_W-1:0] FN_REM_BACK  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_REM_AT    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_SEARCH    = 4'd6;
   localparam logic [FUNC_W-1:0] FN_ADD_ALL   = 4'd7;
   localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd8;

   // Internal operation codes after decoding front and back variants.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_ADDALL = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

endpackage

>>> rtl/core/pcl_ram.sv
// ----------------------------------------------------------------------------
// pcl_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/positional_circular_list.sv
// ----------------------------------------------------------------------------
// positional_circular_list: bounded ordered list kept as a ring in one RAM
// Insert, remove, search, add-to-all and clear on a ring of CAPACITY entries.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; a new request is taken only after the
// previous response is loaded. The walk reads at most CAPACITY entries and
// is bound by the single RAM read port, one entry per cycle.
// Reset: synchronous, clears count, head slot and control; no RAM sweep.
// ----------------------------------------------------------------------------
module positional_circular_list #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pcl_pkg::FUNC_W-1:0]        req_func,
   input  logic [pcl_pkg::POS_W-1:0]         req_position,
   input  logic signed [pcl_pkg::DATA_W-1:0] req_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ok,
   output logic signed [pcl_pkg::DATA_W-1:0] rsp_removed_value,
   output logic                              rsp_found,
   output logic [pcl_pkg::FIDX_W-1:0]        rsp_found_index,
   output logic [pcl_pkg::POS_W-1:0]         rsp_count,
   output logic                              rsp_is_empty,
   output logic signed [pcl_pkg::DATA_W-1:0] rsp_head_value,
   output logic signed [pcl_pkg::DATA_W-1:0] rsp_tail_value
);

   import pcl_pkg::*;

   // Slot addresses the ring; count and walk indices can reach CAPACITY.
   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W   = COUNT_W + 1;
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   // Sequencer states. WALK streams reads through the RAM, FINAL does the
   // last write and updates the count and, on remove or clear, the head; then
   // the head and tail entries are read back before the response is loaded.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_FINAL  = 3'd2;
   localparam logic [2:0] S_RDHEAD = 3'd3;
   localparam logic [2:0] S_RDTAIL = 3'd4;
   localparam logic [2:0] S_CAPT   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   // Map a list index to its ring slot. head is below CAPACITY and idx is
   // at most CAPACITY, so one conditional subtract is enough.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0]  head,
                                                 input logic [COUNT_W-1:0] idx);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(idx);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // Control state.
   logic [2:0]         state_ff,     state_in;
   logic [SLOT_W-1:0]  head_ff,      head_in;
   logic [COUNT_W-1:0] count_ff,     count_in;
   logic [COUNT_W-1:0] walk_left_ff, walk_left_in;
   logic               walk_dv_ff,   walk_dv_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-request payload.
   logic [OP_W-1:0]    op_ff,        op_in;
   logic [COUNT_W-1:0] pos_ff,       pos_in;
   logic [DATA_W-1:0]  val_ff,       val_in;
   logic               ok_ff,        ok_in;
   logic               found_ff,     found_in;
   logic [COUNT_W-1:0] fidx_ff,      fidx_in;
   logic [DATA_W-1:0]  removed_ff,   removed_in;
   logic [DATA_W-1:0]  head_val_ff,  head_val_in;
   logic [DATA_W-1:0]  tail_val_ff,  tail_val_in;
   logic [COUNT_W-1:0] walk_j_ff,    walk_j_in;
   logic [COUNT_W-1:0] walk_dj_ff,   walk_dj_in;

   // Response registers.
   logic               rsp_ok_ff,      rsp_ok_in;
   logic [DATA_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic               rsp_found_ff,   rsp_found_in;
   logic [FIDX_W-1:0]  rsp_fidx_ff,    rsp_fidx_in;
   logic [POS_W-1:0]   rsp_count_ff,   rsp_count_in;
   logic               rsp_empty_ff,   rsp_empty_in;
   logic [DATA_W-1:0]  rsp_head_ff,    rsp_head_in;
   logic [DATA_W-1:0]  rsp_tail_ff,    rsp_tail_in;

   // RAM ports.
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   logic [DATA_W-1:0]  ram_wdata;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [DATA_W-1:0]  ram_rdata;

   // Decode helpers.
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   dec_pos;
   logic [CMP_W-1:0]   fidx_ext;
   logic               is_ins;
   logic               is_rem;
   logic               ins_ok;
   logic               rem_ok;
   logic               accept;
   logic               rsp_free;
   logic [COUNT_W-1:0] rd_idx;
   logic [COUNT_W-1:0] wr_idx;
   logic [COUNT_W-1:0] tail_idx;
   logic [COUNT_W-1:0] count_dec;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_ext  = CMP_W'(count_ff);
   assign fidx_ext = CMP_W'(fidx_ff);
   assign tail_idx = (count_ff == '0) ? '0 : count_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;

   // Front and back variants become positional ones. A remove at the back
   // of an empty list wraps, but the empty check rejects it anyway.
   always_comb begin
      case (req_func)
         FN_ADD_FRONT, FN_REM_FRONT: dec_pos = '0;
         FN_ADD_BACK:                dec_pos = cnt_ext;
         FN_REM_BACK:                dec_pos = cnt_ext - 1'b1;
         default:                    dec_pos = CMP_W'(req_position);
      endcase
   end

   assign is_ins = req_func inside {FN_ADD_FRONT, FN_ADD_BACK, FN_ADD_AT};
   assign is_rem = req_func inside {FN_REM_FRONT, FN_REM_BACK, FN_REM_AT};
   assign ins_ok = (dec_pos <= cnt_ext) && (count_ff < COUNT_W'(CAPACITY));
   assign rem_ok = (count_ff != '0) && (dec_pos < cnt_ext);

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      walk_left_in = walk_left_ff;
      walk_dv_in   = 1'b0;
      walk_j_in    = walk_j_ff;
      walk_dj_in   = walk_dj_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      removed_in   = removed_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      rd_idx       = walk_j_ff;
      wr_idx       = walk_dj_ff;
      ram_we       = 1'b0;
      ram_wdata    = ram_rdata;

      rsp_ok_in      = rsp_ok_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_fidx_in    = rsp_fidx_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_tail_in    = rsp_tail_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in     = S_WALK;
               val_in       = req_value;
               pos_in       = dec_pos[COUNT_W-1:0];
               found_in     = 1'b0;
               fidx_in      = '0;
               removed_in   = '0;
               walk_left_in = '0;
               walk_j_in    = '0;
               ok_in        = 1'b1;
               op_in        = OP_NOP;
               if (is_ins) begin
                  ok_in = ins_ok;
                  if (ins_ok) begin
                     op_in = OP_INSERT;
                     if (dec_pos == '0) begin
                        // Insert at the head just moves the head back.
                        head_in = (head_ff == '0) ? SLOT_W'(CAPACITY - 1)
                                                  : head_ff - 1'b1;
                     end else begin
                        // Shift the tail part up, walking from the end.
                        walk_left_in = COUNT_W'(cnt_ext - dec_pos);
                        walk_j_in    = count_ff - 1'b1;
                     end
                  end
               end else if (is_rem) begin
                  ok_in = rem_ok;
                  if (rem_ok) begin
                     op_in     = OP_REMOVE;
                     walk_j_in = dec_pos[COUNT_W-1:0];
                     // Removing the head reads only that entry; otherwise
                     // the entries behind it are shifted down.
                     walk_left_in = (dec_pos == '0) ? COUNT_W'(1)
                                                    : COUNT_W'(cnt_ext - dec_pos);
                  end
               end else begin
                  case (req_func)
                     FN_SEARCH: begin
                        op_in        = OP_SEARCH;
                        walk_left_in = count_ff;
                     end
                     FN_ADD_ALL: begin
                        op_in        = OP_ADDALL;
                        walk_left_in = count_ff;
                     end
                     FN_CLEAR: begin
                        op_in = OP_CLEAR;
                     end
                     default: begin
                        ok_in = 1'b0;
                     end
                  endcase
               end
            end
         end

         S_WALK: begin
            // Issue stage: one read per cycle.
            rd_idx = walk_j_ff;
            if (walk_left_ff != '0) begin
               walk_dv_in   = 1'b1;
               walk_dj_in   = walk_j_ff;
               walk_left_in = walk_left_ff - 1'b1;
               walk_j_in    = (op_ff == OP_INSERT) ? walk_j_ff - 1'b1
                                                   : walk_j_ff + 1'b1;
            end
            // Data stage: the entry read in the previous cycle. Writes go to
            // indices the issue stage has already passed, so no read ever
            // sees a stale entry and no forwarding is needed.
            if (walk_dv_ff) begin
               case (op_ff)
                  OP_INSERT: begin
                     ram_we = 1'b1;
                     wr_idx = walk_dj_ff + 1'b1;
                  end
                  OP_REMOVE: begin
                     if (walk_dj_ff == pos_ff) begin
                        removed_in = ram_rdata;
                     end else begin
                        ram_we = 1'b1;
                        wr_idx = walk_dj_ff - 1'b1;
                     end
                  end
                  OP_ADDALL: begin
                     ram_we    = 1'b1;
                     ram_wdata = ram_rdata + val_ff;
                  end
                  OP_SEARCH: begin
                     if (!found_ff && (ram_rdata == val_ff)) begin
                        // First match ends the walk; the read issued in
                        // this cycle is dropped by clearing its valid bit.
                        found_in     = 1'b1;
                        fidx_in      = walk_dj_ff;
                        walk_left_in = '0;
                        walk_dv_in   = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if ((walk_left_ff == '0) && !walk_dv_ff) begin
               state_in = S_FINAL;
            end
         end

         S_FINAL: begin
            state_in = S_RDHEAD;
            case (op_ff)
               OP_INSERT: begin
                  ram_we    = 1'b1;
                  wr_idx    = pos_ff;
                  ram_wdata = val_ff;
                  count_in  = count_ff + 1'b1;
               end
               OP_REMOVE: begin
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     head_in = '0;
                  end else if (pos_ff == '0) begin
                     head_in = (head_ff == SLOT_W'(CAPACITY - 1)) ? '0
                                                                  : head_ff + 1'b1;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  head_in  = '0;
               end
               default: begin
               end
            endcase
         end

         S_RDHEAD: begin
            rd_idx   = '0;
            state_in = S_RDTAIL;
         end

         S_RDTAIL: begin
            rd_idx      = tail_idx;
            head_val_in = (count_ff == '0) ? '0 : ram_rdata;
            state_in    = S_CAPT;
         end

         S_CAPT: begin
            tail_val_in = (count_ff == '0) ? '0 : ram_rdata;
            state_in    = S_RESP;
         end

         S_RESP: begin
            // Wait here until the response register is free.
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_ok_in      = ok_ff;
               rsp_removed_in = removed_ff;
               rsp_found_in   = found_ff;
               rsp_fidx_in    = fidx_ext[FIDX_W-1:0];
               rsp_count_in   = cnt_ext[POS_W-1:0];
               rsp_empty_in   = (count_ff == '0);
               rsp_head_in    = head_val_ff;
               rsp_tail_in    = tail_val_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_raddr = slot_of(head_ff, rd_idx);
   assign ram_waddr = slot_of(head_ff, wr_idx);

   pcl_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         walk_left_ff <= '0;
         walk_dv_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         walk_left_ff <= walk_left_in;
         walk_dv_ff   <= walk_dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      ok_ff          <= ok_in;
      found_ff       <= found_in;
      fidx_ff        <= fidx_in;
      removed_ff     <= removed_in;
      head_val_ff    <= head_val_in;
      tail_val_ff    <= tail_val_in;
      walk_j_ff      <= walk_j_in;
      walk_dj_ff     <= walk_dj_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_fidx_ff    <= rsp_fidx_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_tail_ff    <= rsp_tail_in;
   end

   // A new request is taken only while the sequencer is idle; a finished
   // response may still be waiting in the output register at that time.
   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_found_index   = rsp_fidx_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_head_value    = rsp_head_ff;
   assign rsp_tail_value    = rsp_tail_ff;

   // The list never holds more entries than the ring has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The RAM is written only during the walk and the final update, never
   // while head and tail are being read back.
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_WALK || state_ff == S_FINAL))
      else $error("RAM write outside the walk");

   // A failed request reports no removed value and no search hit.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_removed_ff == '0) && !rsp_found_ff)
      else $error("failed request carries result data");

   // A response appears only from the response state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("response loaded outside the response state");

endmodule

>>> bench/tb_positional_circular_list.sv
// ----------------------------------------------------------------------------
// tb_positional_circular_list: self-checking bench for the circular list
// Drives list requests through the valid/stall channel with random gaps,
// predicts each response from a local copy of the ring and checks every
// response field in order.
// ----------------------------------------------------------------------------
module tb_positional_circular_list;
   import pcl_pkg::*;

   localparam int DEPTH = 64;

   // Function codes that the block has to ignore.
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FN_CLEAR + 4'd1;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = '1;

   // One request as it goes on the wire.
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } list_req_type;

   // A planned request; a hold entry makes the sender wait for a drained block.
   typedef struct packed {
      logic         hold;
      list_req_type rq;
   } planned_req_type;

   // One response, field by field.
   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] removed_value;
      logic                     found;
      logic [FIDX_W-1:0]        found_index;
      logic [POS_W-1:0]         count;
      logic                     is_empty;
      logic signed [DATA_W-1:0] head_value;
      logic signed [DATA_W-1:0] tail_value;
   } list_rsp_type;

   // Contents of the ring: the slots, the slot of the head and the entry count.
   typedef struct packed {
      logic [DEPTH-1:0][DATA_W-1:0] slots;
      logic [5:0]                   head;
      logic [POS_W-1:0]             count;
   } ring_type;

   logic clock;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic                     rsp_found;
   logic [FIDX_W-1:0]        rsp_found_index;
   logic [POS_W-1:0]         rsp_count;
   logic                     rsp_is_empty;
   logic signed [DATA_W-1:0] rsp_head_value;
   logic signed [DATA_W-1:0] rsp_tail_value;

   positional_circular_list #(.CAPACITY(DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found         (rsp_found),
      .rsp_found_index   (rsp_found_index),
      .rsp_count         (rsp_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_head_value    (rsp_head_value),
      .rsp_tail_value    (rsp_tail_value)
   );

   // Requests still to be sent, responses still owed by the block.
   planned_req_type request_plan[$];
   list_rsp_type    awaited_rsp[$];

   // The ring as the checker sees it, and a second copy that the stimulus
   // planner advances so that it can aim positions and searches at real data.
   ring_type checked_ring;
   ring_type planned_ring;

   int fail_count = 0;
   int rsp_checked = 0;
   int full_rejects = 0;
   int search_hits = 0;
   int peak_count = 0;

   logic req_fired_ff = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Physical slot that holds list index idx.
   function automatic int ring_slot(input logic [5:0] head, input int idx);
      return (int'(head) + idx) % DEPTH;
   endfunction

   // Applies one request to a ring and works out the response it must give.
   // Front and back variants are folded into the positional insert and remove.
   function automatic void apply_request(input ring_type cur, input list_req_type rq,
                                         output ring_type nxt, output list_rsp_type rs);
      ring_type          s;
      logic [FUNC_W-1:0] op;
      int                pos;
      int                cnt;
      int                i;
      s   = cur;
      rs  = '0;
      op  = rq.func;
      pos = rq.position;
      cnt = s.count;
      case (rq.func)
         FN_ADD_FRONT: begin op = FN_ADD_AT; pos = 0;       end
         FN_ADD_BACK:  begin op = FN_ADD_AT; pos = cnt;     end
         FN_REM_FRONT: begin op = FN_REM_AT; pos = 0;       end
         FN_REM_BACK:  begin op = FN_REM_AT; pos = cnt - 1; end
         default: ;
      endcase
      case (op)
         FN_ADD_AT: begin
            if (pos <= cnt && cnt < DEPTH) begin
               if (pos == 0) begin
                  s.head = s.head - 6'd1;
               end else begin
                  for (i = cnt; i > pos; i--)
                     s.slots[ring_slot(s.head, i)] = s.slots[ring_slot(s.head, i - 1)];
               end
               s.slots[ring_slot(s.head, pos)] = rq.value;
               cnt++;
               rs.ok = 1'b1;
            end
         end
         FN_REM_AT: begin
            if (cnt != 0 && pos >= 0 && pos < cnt) begin
               rs.removed_value = s.slots[ring_slot(s.head, pos)];
               if (pos == 0) begin
                  s.head = s.head + 6'd1;
               end else begin
                  for (i = pos; i + 1 < cnt; i++)
                     s.slots[ring_slot(s.head, i)] = s.slots[ring_slot(s.head, i + 1)];
               end
               cnt--;
               if (cnt == 0) s.head = '0;
               rs.ok = 1'b1;
            end
         end
         FN_SEARCH: begin
            rs.ok = 1'b1;
            for (i = 0; i < cnt && !rs.found; i++) begin
               if (s.slots[ring_slot(s.head, i)] == rq.value) begin
                  rs.found       = 1'b1;
                  rs.found_index = i[FIDX_W-1:0];
               end
            end
         end
         FN_ADD_ALL: begin
            rs.ok = 1'b1;
            for (i = 0; i < cnt; i++)
               s.slots[ring_slot(s.head, i)] = s.slots[ring_slot(s.head, i)] + rq.value;
         end
         FN_CLEAR: begin
            rs.ok = 1'b1;
            cnt = 0;
            s.head = '0;
         end
         default: ;
      endcase
      s.count     = cnt[POS_W-1:0];
      rs.count    = cnt[POS_W-1:0];
      rs.is_empty = (cnt == 0);
      if (cnt != 0) begin
         rs.head_value = s.slots[ring_slot(s.head, 0)];
         rs.tail_value = s.slots[ring_slot(s.head, cnt - 1)];
      end
      nxt = s;
   endfunction

   // Queues one request and advances the planner's copy of the ring.
   task automatic plan_request(input logic [FUNC_W-1:0] func, input int position,
                               input logic [DATA_W-1:0] value);
      planned_req_type p;
      list_rsp_type    unused_rsp;
      p.hold        = 1'b0;
      p.rq.func     = func;
      p.rq.position = position[POS_W-1:0];
      p.rq.value    = value;
      apply_request(planned_ring, p.rq, planned_ring, unused_rsp);
      request_plan.push_back(p);
   endtask

   // Queues a pause: the sender waits until every response has come back.
   task automatic plan_drain();
      planned_req_type p;
      p      = '0;
      p.hold = 1'b1;
      request_plan.push_back(p);
   endtask

   // Data values: a small pool so that searches hit, small negative values,
   // the extremes and fully random words.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom_range(0, 15);
         2:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Inputs change on the falling edge. A request that is
   // offered stays on the wire, unchanged, until the rising edge that takes
   // it (valid high, stall low). Between requests the sender may go quiet
   // for a random burst, except near the end of the run.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      planned_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired_ff) begin
         // Still waiting for the block to take the current request.
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (request_plan.size() == 0) begin
         req_valid <= 1'b0;
      end else if (request_plan[0].hold) begin
         // Pause until the block has answered everything sent so far.
         req_valid <= 1'b0;
         if (awaited_rsp.size() == 0) next_req = request_plan.pop_front();
      end else if (request_plan.size() >= 40 && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         gap_left = $urandom_range(0, 13);
      end else begin
         next_req = request_plan.pop_front();
         req_valid    <= 1'b1;
         req_func     <= next_req.rq.func;
         req_position <= next_req.rq.position;
         req_value    <= next_req.rq.value;
      end
   end

   // Response stall, also in random bursts and released near the end.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (request_plan.size() >= 40 && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. On every rising edge a response that is taken is compared with
   // the oldest expectation, and a request that is taken is run through the
   // predictor, which queues the response it must produce.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      list_rsp_type want;
      list_req_type taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, got ok=%0b count=%0d",
                        $time, rsp_ok, rsp_count);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               rsp_checked++;
               if (rsp_ok !== want.ok)
                  note_mismatch("ok", DATA_W'(want.ok), DATA_W'(rsp_ok));
               if (rsp_removed_value !== want.removed_value)
                  note_mismatch("removed_value", want.removed_value, rsp_removed_value);
               if (rsp_found !== want.found)
                  note_mismatch("found", DATA_W'(want.found), DATA_W'(rsp_found));
               if (rsp_found_index !== want.found_index)
                  note_mismatch("found_index", DATA_W'(want.found_index),
                                DATA_W'(rsp_found_index));
               if (rsp_count !== want.count)
                  note_mismatch("count", DATA_W'(want.count), DATA_W'(rsp_count));
               if (rsp_is_empty !== want.is_empty)
                  note_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp_is_empty));
               if (rsp_head_value !== want.head_value)
                  note_mismatch("head_value", want.head_value, rsp_head_value);
               if (rsp_tail_value !== want.tail_value)
                  note_mismatch("tail_value", want.tail_value, rsp_tail_value);
            end
         end
         if (req_valid && !req_stall) begin
            taken.func     = req_func;
            taken.position = req_position;
            taken.value    = req_value;
            if (checked_ring.count == DEPTH &&
                (req_func == FN_ADD_FRONT || req_func == FN_ADD_BACK || req_func == FN_ADD_AT))
               full_rejects++;
            apply_request(checked_ring, taken, checked_ring, want);
            if (want.found) search_hits++;
            if (int'(want.count) > peak_count) peak_count = int'(want.count);
            awaited_rsp.push_back(want);
         end
      end
      req_fired_ff <= !reset && req_valid && !req_stall;
   end

   // ------------------------------------------------------------------------
   // Stimulus plan and end of run.
   // ------------------------------------------------------------------------
   initial begin
      int                  n;
      int                  phase;
      int                  mode;
      int                  cnt;
      int                  roll;
      int                  ins_pct;
      int                  rem_pct;
      logic [FUNC_W-1:0]   f;
      logic [DATA_W-1:0]   v;
      checked_ring = '0;
      planned_ring = '0;

      // Directed part: removes, search, add-all and out-of-range inserts on an
      // empty list, the value extremes, add-all wrapping, positions at and beyond
      // the count, ignored codes, clear, and an insert at the head of an empty list.
      plan_request(FN_REM_FRONT, 0, 0);
      plan_request(FN_REM_BACK, 0, 0);
      plan_request(FN_REM_AT, 0, 0);
      plan_request(FN_SEARCH, 0, 0);
      plan_request(FN_ADD_ALL, 0, 5);
      plan_request(FN_ADD_AT, 1, 7);
      plan_request(FN_ADD_AT, 127, 7);
      plan_request(FN_ADD_FRONT, 0, 32'h7FFF_FFFF);
      plan_request(FN_ADD_BACK, 0, 32'h8000_0000);
      plan_request(FN_ADD_AT, 1, 0);
      plan_request(FN_ADD_AT, 3, 32'hFFFF_FFFF);
      plan_request(FN_SEARCH, 0, 32'hFFFF_FFFF);
      plan_request(FN_SEARCH, 0, 12345);
      plan_request(FN_ADD_ALL, 0, 1);
      plan_request(FN_REM_AT, 1, 0);
      plan_request(FN_REM_AT, 64, 0);
      plan_request(FN_REM_AT, 127, 0);
      plan_request(FN_UNUSED_LO, 5, 32'hFFFF_FFFF);
      plan_request(FN_UNUSED_HI, 127, 32'h1234_5678);
      plan_request(FN_REM_BACK, 0, 0);
      plan_request(FN_REM_FRONT, 0, 0);
      plan_request(FN_CLEAR, 0, 0);
      plan_request(FN_ADD_AT, 0, 42);
      plan_request(FN_REM_AT, 0, 0);
      plan_drain();

      // Random part in phases of 50 requests. The first phases fill the list
      // to capacity and then drain it again; later phases pick a mode at
      // random. Positions mostly land inside the list, searches mostly look
      // for a value that is present.
      n = 0;
      phase = -1;
      while (n < 500) begin
         if (n / 50 != phase) begin
            phase = n / 50;
            case (phase)
               0, 1:    mode = 0;
               2:       mode = 2;
               3, 4:    mode = 1;
               default: mode = $urandom_range(0, 2);
            endcase
            if (phase == 5) plan_drain();
         end
         cnt     = planned_ring.count;
         roll    = $urandom_range(0, 99);
         ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 45;
         rem_pct = (mode == 0) ? 5  : (mode == 1) ? 60 : 30;
         if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
               0:       f = FN_ADD_FRONT;
               1:       f = FN_ADD_BACK;
               default: f = FN_ADD_AT;
            endcase
            plan_request(f, ($urandom_range(0, 99) < 85) ? $urandom_range(0, cnt)
                                                         : $urandom_range(0, 127),
                         pick_value());
            n++;
         end else if (roll < ins_pct + rem_pct) begin
            case ($urandom_range(0, 2))
               0:       f = FN_REM_FRONT;
               1:       f = FN_REM_BACK;
               default: f = FN_REM_AT;
            endcase
            plan_request(f, (cnt > 0 && $urandom_range(0, 99) < 85)
                            ? $urandom_range(0, cnt - 1) : $urandom_range(0, 127),
                         $urandom);
            n++;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               if (cnt > 0 && $urandom_range(0, 99) < 70)
                  v = planned_ring.slots[ring_slot(planned_ring.head,
                                                   $urandom_range(0, cnt - 1))];
               else
                  v = pick_value();
               plan_request(FN_SEARCH, $urandom_range(0, 127), v);
               n++;
            end else if (roll < 88) begin
               case ($urandom_range(0, 4))
                  0:       v = 0;
                  1:       v = 1;
                  2:       v = 32'hFFFF_FFFF;
                  3:       v = 32'h8000_0000;
                  default: v = $urandom;
               endcase
               plan_request(FN_ADD_ALL, $urandom_range(0, 127), v);
               n++;
            end else if (roll < 94) begin
               plan_request(FN_CLEAR, $urandom_range(0, 127), $urandom);
               n++;
            end else begin
               // Ignored codes do not count toward the request total.
               plan_request(FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)),
                            $urandom_range(0, 127), $urandom);
            end
         end
      end

      // Synchronous reset, released on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every request to be taken and answered, then give the block
      // time to show any response it should not produce.
      while (request_plan.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Checked %0d responses; peak list length %0d, %0d inserts into a full list,",
               rsp_checked, peak_count, full_rejects);
      $display("%0d searches found their value, %0d mismatches.", search_hits, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Run timed out with %0d responses outstanding.", awaited_rsp.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
